[hdl/rac_pkg.sv]
package rac_pkg;

    // radix limits and field widths
    localparam int unsigned RADIX_W   = 6;
    localparam int unsigned DIGIT_W   = 6;
    localparam int unsigned CHAR_W    = 7;
    localparam int unsigned RADIX_MIN = 2;
    localparam int unsigned RADIX_MAX = 36;
    localparam int unsigned DIGIT_TOP = 35;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 7'h41;
    localparam logic [CHAR_W-1:0]  CHAR_NONE  = 7'h00;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

    // divider status toward the sequencer
    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] remainder;
    } div_status_t;

    // digit value to ascii, 0-9 then A-Z, clamped at Z
    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] dc;
        logic [CHAR_W-1:0]  ch;
        dc = (d > DIGIT_W'(DIGIT_TOP)) ? DIGIT_W'(DIGIT_TOP) : d;
        if (dc < DEC_DIGITS)
            ch = CHAR_ZERO + CHAR_W'(dc);
        else
            ch = CHAR_ALPHA + CHAR_W'(dc - DEC_DIGITS);
        return ch;
    endfunction

    function automatic logic radix_ok(input logic [RADIX_W-1:0] r);
        return (r >= RADIX_W'(RADIX_MIN)) && (r <= RADIX_W'(RADIX_MAX));
    endfunction

endpackage

[hdl/rac_divider.sv]
module rac_divider #(
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [VALUE_BITS-1:0]          dividend,
    input  logic [rac_pkg::RADIX_W-1:0]    divisor,
    output logic [VALUE_BITS-1:0]          quotient,
    output rac_pkg::div_status_t           status
);

    localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0]          q_reg, q_next;
    logic [rac_pkg::DIGIT_W-1:0]    rem_reg, rem_next;
    logic [rac_pkg::RADIX_W-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [rac_pkg::DIGIT_W:0]      trial;
    logic                           fits;

    // restoring step: shift in next dividend bit, subtract if it fits
    assign trial = {rem_reg, q_reg[VALUE_BITS-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[VALUE_BITS-2:0], fits};
            rem_next = fits ? rac_pkg::DIGIT_W'(trial - {1'b0, dvs_reg})
                            : rac_pkg::DIGIT_W'(trial);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient         = q_reg;
    assign status.done      = done_reg;
    assign status.remainder = rem_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ({1'b0, rem_reg} < {1'b0, dvs_reg}))
        else $error("remainder not below divisor");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !$past(start) && $past(busy_reg))
        else $error("done without a running division");

endmodule

[hdl/rac_digit_buffer.sv]
module rac_digit_buffer #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [$clog2(DEPTH)-1:0]           wr_addr,
    input  logic [rac_pkg::DIGIT_W-1:0]        wr_data,
    input  logic                               rd_en,
    input  logic [$clog2(DEPTH)-1:0]           rd_addr,
    output logic [rac_pkg::DIGIT_W-1:0]        rd_data
);

    logic [rac_pkg::DIGIT_W-1:0] mem [DEPTH];
    logic [rac_pkg::DIGIT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/radix_to_ascii_converter_core.sv]
// timing: a bad radix puts its single result on the output the cycle after the request is taken
// a good radix runs each digit through the shared bit-serial divider,
// then replays each digit through buffer read, output load and handoff, waiting out any stall
// requests: one at a time, a new one is taken only in idle
// reset: rst_n asynchronous active low, returns to idle with no result pending
module radix_to_ascii_converter_core #(
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // value [63:0], radix [69:64], zero pad [71:70]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // digit_char [6:0], zero pad [7]
    output logic        m_tlast,   // last
    output logic        m_tuser    // bad_radix
);

    localparam int unsigned MAX_DIGITS = VALUE_BITS;
    localparam int unsigned AW         = $clog2(MAX_DIGITS);
    localparam int unsigned CW         = $clog2(MAX_DIGITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_RDW,
        ST_OUT
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [AW-1:0]                   ptr_reg, ptr_next;
    logic [rac_pkg::RADIX_W-1:0]     radix_reg, radix_next;
    logic                            ovalid_reg, ovalid_next;
    logic [rac_pkg::CHAR_W-1:0]      ochar_reg, ochar_next;
    logic                            olast_reg, olast_next;
    logic                            obad_reg, obad_next;

    // request fields
    logic [63:0]                     in_value;
    logic [rac_pkg::RADIX_W-1:0]     in_radix;

    // divider hookup
    logic                            div_start;
    logic [VALUE_BITS-1:0]           div_dividend;
    logic [rac_pkg::RADIX_W-1:0]     div_divisor;
    logic [VALUE_BITS-1:0]           div_quotient;
    rac_pkg::div_status_t            div_st;

    // digit buffer hookup
    logic                            wr_en;
    logic                            rd_en;
    logic [rac_pkg::DIGIT_W-1:0]     rd_data;

    assign in_value = s_tdata[63:0];
    assign in_radix = s_tdata[69:64];

    assign s_tready = (state_reg == ST_IDLE);

    rac_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_st)
    );

    rac_digit_buffer #(
        .DEPTH (MAX_DIGITS)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (div_st.remainder),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    // sequencer: divide repeatedly, store digits lsd first, replay them msd first; a bad radix gives one flagged result
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        radix_next   = radix_reg;
        ovalid_next  = ovalid_reg;
        ochar_next   = ochar_reg;
        olast_next   = olast_reg;
        obad_next    = obad_reg;
        div_start    = 1'b0;
        div_dividend = in_value[VALUE_BITS-1:0];
        div_divisor  = radix_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                div_divisor = in_radix;
                if (s_tvalid)
                begin
                    count_next = '0;
                    radix_next = in_radix;
                    if (!rac_pkg::radix_ok(in_radix))
                    begin
                        // bad radix: one flagged result, nothing divided
                        ovalid_next = 1'b1;
                        ochar_next  = rac_pkg::CHAR_NONE;
                        olast_next  = 1'b1;
                        obad_next   = 1'b1;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                // later passes reuse the radix held from the request
                div_dividend = div_quotient;
                if (div_st.done)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (div_quotient == '0)
                    begin
                        // newest digit is the most significant
                        ptr_next   = count_reg[AW-1:0];
                        state_next = ST_RD;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_RDW;
            end
            ST_RDW:
            begin
                ovalid_next = 1'b1;
                ochar_next  = rac_pkg::glyph(rd_data);
                olast_next  = (ptr_reg == '0);
                obad_next   = 1'b0;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    ovalid_next = 1'b0;
                    if (olast_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg - 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ptr_reg    <= '0;
            radix_reg  <= '0;
            ovalid_reg <= 1'b0;
            ochar_reg  <= '0;
            olast_reg  <= 1'b0;
            obad_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            radix_reg  <= radix_next;
            ovalid_reg <= ovalid_next;
            ochar_reg  <= ochar_next;
            olast_reg  <= olast_next;
            obad_reg   <= obad_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {1'b0, ochar_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = obad_reg;

    // error results are always single and carry no character
    a_bad_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[6:0] == rac_pkg::CHAR_NONE)))
        else $error("bad radix result malformed");

    // no request is taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("request taken with result pending");

    // the divider only finishes while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside division phase");

    // digit count never exceeds the buffer depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_DIGITS))
        else $error("digit count past buffer depth");

endmodule

[dv/rac_checker.sv]
`timescale 1ns / 100ps

module rac_checker #(
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // value [63:0], radix [69:64], zero pad [71:70]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // digit_char [6:0], zero pad [7]
    input  logic        m_tlast,   // last
    input  logic        m_tuser,   // bad_radix
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [rac_pkg::CHAR_W-1:0] char_code;
        logic                       last;
        logic                       bad_radix;
    } digit_out_t;

    localparam logic [63:0]     VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam logic [8*36-1:0] GLYPHS     = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

    digit_out_t pending_digits[$];
    int         fail_count = 0;
    int         queued     = 0;

    assign mismatches  = fail_count;
    assign outstanding = queued;

    // first character of the string sits in the top byte
    function automatic logic [rac_pkg::CHAR_W-1:0] digit_ascii(
        input logic [rac_pkg::DIGIT_W-1:0] d);
        return rac_pkg::CHAR_W'(GLYPHS[8*(35 - int'(d)) +: 8]);
    endfunction

    // expand one request into its digit characters, most significant first; a bad radix gives one flagged entry
    function automatic void predict_conversion(input logic [63:0]                 raw,
                                               input logic [rac_pkg::RADIX_W-1:0] radix);
        logic [63:0]                 quotient;
        logic [rac_pkg::DIGIT_W-1:0] lsd_first[$];
        digit_out_t                  entry;
        if (radix < rac_pkg::RADIX_W'(rac_pkg::RADIX_MIN) ||
            radix > rac_pkg::RADIX_W'(rac_pkg::RADIX_MAX))
        begin
            entry.char_code = rac_pkg::CHAR_NONE;
            entry.last      = 1'b1;
            entry.bad_radix = 1'b1;
            pending_digits  = {pending_digits, entry};
            return;
        end
        quotient = raw & VALUE_MASK;
        do
        begin
            lsd_first = {lsd_first, rac_pkg::DIGIT_W'(quotient % 64'(radix))};
            quotient  = quotient / 64'(radix);
        end while (quotient != 0);
        while (lsd_first.size() != 0)
        begin
            entry.char_code = digit_ascii(lsd_first.pop_back());
            entry.last      = (lsd_first.size() == 0);
            entry.bad_radix = 1'b0;
            pending_digits  = {pending_digits, entry};
        end
    endfunction

    always @(posedge clk)
    begin
        digit_out_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_conversion(s_tdata[63:0], s_tdata[64 +: rac_pkg::RADIX_W]);
            if (m_tvalid && m_tready)
            begin
                if (pending_digits.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("rac_checker: unexpected result tdata %h tlast %b tuser %b",
                                 m_tdata, m_tlast, m_tuser);
                end
                else
                begin
                    want = pending_digits.pop_front();
                    if (m_tdata !== {1'b0, want.char_code} || m_tlast !== want.last ||
                        m_tuser !== want.bad_radix)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("rac_checker: exp %h %b %b, got %h %b %b",
                                     {1'b0, want.char_code}, want.last, want.bad_radix,
                                     m_tdata, m_tlast, m_tuser);
                    end
                end
            end
        end
        queued <= pending_digits.size();
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned VALUE_BITS  = 64;
    localparam int          RANDOM_REQS = 120;
    // a 64-digit binary conversion keeps both sides quiet through its whole division phase
    localparam int          QUIET_LIMIT = 20000;

    // receiver stall patterns, picked at random
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_WINDOW
    } rx_mode_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;   // value [63:0], radix [69:64], zero pad [71:70]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // digit_char [6:0], zero pad [7]
    logic        m_tlast;         // last
    logic        m_tuser;         // bad_radix

    int       mismatches;
    int       outstanding;
    int       burst_left  = 0;
    int       quiet_cycles = 0;
    int       rx_cycle    = 0;
    rx_mode_t rx_mode     = RX_ALWAYS;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    radix_to_ascii_converter_core #(
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    rac_checker #(
        .VALUE_BITS (VALUE_BITS)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // receiver: pattern picked at random, including stretches with no stall
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 150 == 149)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_ALWAYS: m_tready <= 1'b1;
            RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= ((rx_cycle % 16) < 5);
        endcase
    end

    // watchdog on cycles where neither side moves anything
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    // one request; idle gaps only at burst boundaries, valid held across a burst
    task automatic send_request(input logic [63:0] value,
                                input logic [rac_pkg::RADIX_W-1:0] radix);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, radix, value};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // hold off the sender until the last digit of every request is out
    task automatic drain_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        logic [63:0]                 value;
        logic [rac_pkg::RADIX_W-1:0] radix;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero in several bases
        send_request(64'd0, 6'd10);
        send_request(64'd0, 6'd2);
        send_request(64'd0, 6'd36);
        // all ones: longest digit string in binary, plus other bases
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 6'd2);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 6'd36);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 6'd16);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 6'd10);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 6'd8);
        // single digits, digit roll-over at the top base, then the top bit alone and a mixed pattern
        send_request(64'd1, 6'd2);
        send_request(64'd35, 6'd36);
        send_request(64'd36, 6'd36);
        send_request(64'd9, 6'd10);
        send_request(64'd10, 6'd11);
        send_request(64'h8000_0000_0000_0000, 6'd2);
        send_request(64'h8000_0000_0000_0000, 6'd3);
        send_request(64'h5555_AAAA_0F0F_F0F0, 6'd7);
        // radix out of range below and above
        send_request(64'h1234_5678_9ABC_DEF0, 6'd0);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 6'd1);
        send_request(64'd0, 6'd37);
        send_request(64'hA5A5_A5A5_A5A5_A5A5, 6'd63);
        send_request(64'd12345, 6'd62);
        drain_results();

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if ($urandom_range(0, 99) < 15)
                radix = ($urandom_range(0, 1) == 0)
                        ? rac_pkg::RADIX_W'($urandom_range(0, 1))
                        : rac_pkg::RADIX_W'($urandom_range(37, 63));
            else
                radix = rac_pkg::RADIX_W'($urandom_range(rac_pkg::RADIX_MIN,
                                                         rac_pkg::RADIX_MAX));
            case ($urandom_range(0, 3))
                0: value = {$urandom, $urandom};
                1: value = {$urandom, $urandom} >> $urandom_range(1, 63);
                2: value = 64'($urandom_range(0, 2000));
                default: value = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
            endcase
            send_request(value, radix);
            if (n % 40 == 39)
                drain_results();
        end

        drain_results();
        repeat (16) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
